>>> design/pwte_pkg.sv
// Shared types and constants for the pixel word time extender.
`default_nettype none

package pwte_pkg;

	localparam int WORD_W  = 64;
	localparam int DELTA_W = 27;

	localparam logic [1:0] KIND_IGNORED   = 2'd0;
	localparam logic [1:0] KIND_HIT       = 2'd1;
	localparam logic [1:0] KIND_HEARTBEAT = 2'd2;
	localparam logic [1:0] KIND_SECOND_T0 = 2'd3;

	localparam logic [3:0] HDR_HEARTBEAT = 4'h4;
	localparam logic [3:0] HDR_PIXEL_A   = 4'hA;
	localparam logic [3:0] HDR_PIXEL_B   = 4'hB;
	localparam logic [3:0] SUB_TIME_LOW  = 4'h4;
	localparam logic [3:0] SUB_TIME_HIGH = 4'h5;

	localparam logic [DELTA_W-1:0] DELTA_T0_RESET = 27'd1000000;

	// 6 s expressed in sync ticks (4096 * 40 ticks per microsecond)
	localparam logic [WORD_W-1:0] CLEAR_LIMIT = 64'd983040000000;

	// wrap window is 2^42 ticks, centered tolerance 2^41
	localparam logic [WORD_W-1:0] WRAP_HALF = 64'h0000_0200_0000_0000;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] column;
		logic [7:0] row_index;
		logic [9:0] tot_count;
	} hit_t;

	// t * 1000, modulo 2^64
	function automatic logic [WORD_W-1:0] times_1000(input logic [WORD_W-1:0] t);
		times_1000 = (t << 10) - (t << 4) - (t << 3);
	endfunction

	// (p / 4096) * 25, modulo 2^64
	function automatic logic [WORD_W-1:0] to_ps(input logic [WORD_W-1:0] p);
		logic [WORD_W-1:0] q;
		q = p >> 12;
		to_ps = (q << 4) + (q << 3) + q;
	endfunction

endpackage

`default_nettype wire

>>> design/pixel_word_time_extender_top.sv
// Top level: stream ports, pipeline control and stage registers.
`default_nettype none

// One result per readout word, in order. A word is taken every cycle when the
// output side keeps up; a result passes input register, decode, wrap correction,
// scale by 1000 and scale to ps in turn. The sync-time state is updated as a
// word leaves the input register, so each word sees all heartbeats before it.
// The user must write the jump limit with cfg_we while idle; no check enforces it.
module pixel_word_time_extender_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [26:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // [63:0] packet_word
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [95:0]      m_axis_tdata,  // [7:0] column, [15:8] row_index,
	                                        // [25:16] tot_count, [89:26] hit_time_ps, zero fill
	output logic [1:0]       m_axis_tuser   // [1:0] kind
);
	import pwte_pkg::*;

	logic en_out, en4, en3, en2, en1;
	logic v1_q, v2_q, v3_q, v4_q, vo_q;

	logic [WORD_W-1:0] word_s1;
	hit_t              hit_s2, hit_s3, hit_s4, hit_c;
	logic [WORD_W-1:0] t_s2, sync_s2, t_s3, p_s4;
	logic [WORD_W-1:0] t_c, sync_c, fixed_c;
	logic [95:0]       out_data_q;
	logic [1:0]        out_kind_q;

	// each stage moves when the next one is empty or moving
	assign en_out = !vo_q || m_axis_tready;
	assign en4    = !v4_q || en_out;
	assign en3    = !v3_q || en4;
	assign en2    = !v2_q || en3;
	assign en1    = !v1_q || en2;

	assign s_axis_tready = en1;
	assign m_axis_tvalid = vo_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;

	pwte_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.fire     (v1_q && en2),
		.word     (word_s1),
		.hit      (hit_c),
		.hit_time (t_c),
		.sync_now (sync_c)
	);

	pwte_wrap u_wrap (
		.hit_time   (t_s2),
		.sync_time  (sync_s2),
		.fixed_time (fixed_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= s_axis_tvalid;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				v3_q <= v2_q;
			end
			if (en4) begin
				v4_q <= v3_q;
			end
			if (en_out) begin
				vo_q <= v4_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			word_s1 <= s_axis_tdata;
		end
		if (en2) begin
			hit_s2  <= hit_c;
			t_s2    <= t_c;
			sync_s2 <= sync_c;
		end
		if (en3) begin
			hit_s3 <= hit_s2;
			t_s3   <= fixed_c;
		end
		if (en4) begin
			hit_s4 <= hit_s3;
			p_s4   <= times_1000(t_s3);
		end
		if (en_out) begin
			out_kind_q <= hit_s4.kind;
			// time is reported only for hits
			out_data_q <= {6'd0,
				(hit_s4.kind == KIND_HIT) ? to_ps(p_s4) : {WORD_W{1'b0}},
				hit_s4.tot_count, hit_s4.row_index, hit_s4.column};
		end
	end

endmodule

`default_nettype wire

>>> design/pwte_front.sv
// Word decode, heartbeat sync-time state and raw hit time assembly.
`default_nettype none

module pwte_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [pwte_pkg::DELTA_W-1:0]      cfg_data,
	input  wire logic                              fire,
	input  wire logic [pwte_pkg::WORD_W-1:0]       word,
	output pwte_pkg::hit_t                         hit,
	output logic      [pwte_pkg::WORD_W-1:0]       hit_time,
	output logic      [pwte_pkg::WORD_W-1:0]       sync_now
);
	import pwte_pkg::*;

	logic [DELTA_W-1:0] delta_q;
	logic [WORD_W-1:0]  sync_q;
	logic [WORD_W-1:0]  prev_q;
	logic               cleared_q;

	logic [3:0]        hdr;
	logic [3:0]        sub;
	logic              hb_ok;
	logic              is_pixel;
	logic [WORD_W-1:0] sync_lo;
	logic [WORD_W-1:0] sync_hi;
	logic [WORD_W-1:0] scaled_delta;
	logic              clear_now;
	logic              jump_back;
	logic [3:0]        phase;

	assign hdr      = word[63:60];
	assign sub      = word[59:56];
	assign hb_ok    = (word[55:48] == 8'd0) && ((sub == SUB_TIME_LOW) || (sub == SUB_TIME_HIGH));
	assign is_pixel = cleared_q && ((hdr == HDR_PIXEL_A) || (hdr == HDR_PIXEL_B));

	assign sync_lo = {sync_q[63:44], word[47:16], 12'd0};
	assign sync_hi = {4'd0, word[31:16], sync_q[43:0]};

	// jump limit * 163840 = (limit << 17) + (limit << 15)
	assign scaled_delta = {20'd0, delta_q, 17'd0} + {22'd0, delta_q, 15'd0};
	assign clear_now    = !cleared_q && (sync_hi < CLEAR_LIMIT);
	assign jump_back    = (sync_hi + scaled_delta) < prev_q;

	assign phase = word[56:53] - 4'd1;

	always_comb begin
		hit = '0;
		if (hdr == HDR_HEARTBEAT) begin
			if (hb_ok) begin
				if (sub == SUB_TIME_HIGH && !clear_now && jump_back) begin
					hit.kind = KIND_SECOND_T0;
				end else begin
					hit.kind = KIND_HEARTBEAT;
				end
			end
		end else if (is_pixel) begin
			hit.kind      = KIND_HIT;
			hit.column    = {word[59:53], word[46]};
			hit.row_index = {word[52:47], word[45:44]};
			hit.tot_count = word[29:20];
		end
	end

	assign hit_time = {sync_q[63:42], word[15:0], word[43:30], ~word[19:16], 8'd0}
		+ {52'd0, phase, 8'd0};
	assign sync_now = sync_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_q <= DELTA_T0_RESET;
		end else if (cfg_we) begin
			delta_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q    <= '0;
			prev_q    <= '0;
			cleared_q <= 1'b0;
		end else if (fire && hdr == HDR_HEARTBEAT && hb_ok) begin
			if (sub == SUB_TIME_LOW) begin
				sync_q <= sync_lo;
			end else begin
				sync_q <= sync_hi;
				if (clear_now) begin
					cleared_q <= 1'b1;
					prev_q    <= sync_hi;
				end else if (!jump_back) begin
					prev_q <= sync_hi;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> design/pwte_wrap.sv
// Pixel-clock wrap correction of the raw hit time against the sync time.
`default_nettype none

module pwte_wrap (
	input  wire logic [pwte_pkg::WORD_W-1:0] hit_time,
	input  wire logic [pwte_pkg::WORD_W-1:0] sync_time,
	output logic      [pwte_pkg::WORD_W-1:0] fixed_time
);
	import pwte_pkg::*;

	logic [WORD_W-1:0] diff;
	logic [WORD_W-1:0] rounded;
	logic              too_far;

	assign diff    = sync_time - hit_time;
	// diff - 2^41 + (2^42 - 1) == sync + ~t + 2^41
	assign rounded = sync_time + ~hit_time + WRAP_HALF;
	assign too_far = !diff[63] && (diff > WRAP_HALF);

	// advance the upper part by whole 2^42 periods
	assign fixed_time = too_far
		? {hit_time[63:42] + rounded[63:42], hit_time[41:0]}
		: hit_time;

endmodule

`default_nettype wire
